/* hdl/mvl_pkg.sv */
// ----------------------------------------------------------------------------
// mvl_pkg: shared types and constants for the mode value lister
// Field widths, value range, cell data and control structs, clamp function.
// ----------------------------------------------------------------------------
package mvl_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VAL_W         = 8;
  localparam int CNT_W         = 7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = -8'sd100;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 8'sd100;

  // value travelling along the chain looking for its bin
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
  } tok_t;

  // contents of one cell: a distinct value and its occurrence count
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
    logic [CNT_W-1:0]        cnt;
  } cell_data_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic rotate;
    logic clear;
  } cell_ctl_t;

  function automatic logic signed [VAL_W-1:0] sat_value(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    r = v;
    if (v < VAL_MIN) begin
      r = VAL_MIN;
    end else if (v > VAL_MAX) begin
      r = VAL_MAX;
    end
    return r;
  endfunction

endpackage

/* hdl/mvl_cell.sv */
// ----------------------------------------------------------------------------
// mvl_cell: one cell of the distinct-value chain
// Absorbs a passing value that matches (count up) or claims an empty cell;
// otherwise forwards it right. In rotate mode takes its right neighbor's data; clear empties it.
// ----------------------------------------------------------------------------
module mvl_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mvl_pkg::cell_ctl_t    ctl,
  input  mvl_pkg::tok_t         tok_in,
  output mvl_pkg::tok_t         tok_out,
  input  mvl_pkg::cell_data_t   data_in,
  output mvl_pkg::cell_data_t   data_out
);

  logic                            vld_r, vld_nxt;
  logic signed [mvl_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [mvl_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            tvld_r, tvld_nxt;
  logic signed [mvl_pkg::VAL_W-1:0] tval_r;
  logic                            hit;

  assign hit = vld_r && (val_r == tok_in.val);

  always_comb begin
    vld_nxt  = vld_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    tvld_nxt = 1'b0;
    if (ctl.clear) begin
      vld_nxt = 1'b0;
    end else if (ctl.rotate) begin
      vld_nxt = data_in.vld;
      val_nxt = data_in.val;
      cnt_nxt = data_in.cnt;
    end else if (tok_in.vld) begin
      if (!vld_r) begin
        vld_nxt = 1'b1;
        val_nxt = tok_in.val;
        cnt_nxt = mvl_pkg::CNT_W'(1);
      end else if (hit) begin
        cnt_nxt = cnt_r + mvl_pkg::CNT_W'(1);
      end else begin
        tvld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      tvld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      tvld_r <= tvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
    tval_r <= tok_in.val;
  end

  assign tok_out.vld   = tvld_r;
  assign tok_out.val   = tval_r;
  assign data_out.vld  = vld_r;
  assign data_out.val  = val_r;
  assign data_out.cnt  = cnt_r;

endmodule

/* hdl/mode_value_lister.sv */
// ----------------------------------------------------------------------------
// mode_value_lister: lists every mode of a value set, ties included
// Values stream into a chain of MAX_ITEMS cells holding distinct values and
// counts; after the final item the chain is rotated twice past cell 0.
// ----------------------------------------------------------------------------
// Loading: one item per cycle, busy stays low until the final item.
// After the final item busy stays high through three passes: the last value
// walks the chain, the chain is rotated to find the top count, and it is then
// rotated again to emit the matches (at most one per cycle).
// Results cannot be stalled. Reset (rst_n low, synchronous) empties the set.
module mode_value_lister #(
  parameter int MAX_ITEMS = mvl_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [mvl_pkg::VAL_W-1:0]  in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  output logic signed [mvl_pkg::VAL_W-1:0]  out_mode_value,
  output logic [mvl_pkg::CNT_W-1:0]         out_frequency,
  output logic                              out_overflow,
  output logic                              out_end_of_list
);

  localparam int IW = $clog2(MAX_ITEMS + 1);          // fill count width
  localparam int SW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1; // phase counter

  localparam logic [1:0] ST_IDLE  = 2'd0;  // taking items
  localparam logic [1:0] ST_DRAIN = 2'd1;  // last value still walking the chain
  localparam logic [1:0] ST_SCAN  = 2'd2;  // rotation 1: find top count, ties
  localparam logic [1:0] ST_EMIT  = 2'd3;  // rotation 2: emit matching values

  logic [1:0]                       state_r, state_nxt;
  logic [SW-1:0]                    step_r, step_nxt;
  logic [IW-1:0]                    fill_r, fill_nxt;
  logic                             ovf_r, ovf_nxt;       // drops in current set
  logic                             set_ovf_r, set_ovf_nxt; // flag for output
  logic [mvl_pkg::CNT_W-1:0]        best_r, best_nxt;
  logic [mvl_pkg::CNT_W-1:0]        ties_r, ties_nxt;
  logic [mvl_pkg::CNT_W-1:0]        sent_r, sent_nxt;
  mvl_pkg::tok_t                    tok_r, tok_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic signed [mvl_pkg::VAL_W-1:0] out_val_r;
  logic [mvl_pkg::CNT_W-1:0]        out_cnt_r;
  logic                             out_ovf_r;
  logic                             out_eol_r;

  logic                             accept;
  logic                             room;
  logic                             step_end;
  logic                             hit;
  mvl_pkg::cell_ctl_t               ctl;
  mvl_pkg::tok_t                    tok_w [MAX_ITEMS+1];
  mvl_pkg::cell_data_t              cell_w [MAX_ITEMS];

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign room     = (fill_r < IW'(MAX_ITEMS));
  assign step_end = (step_r == SW'(MAX_ITEMS - 1));

  // cell 0 is always the one looked at; rotation brings each cell past it
  assign hit = (state_r == ST_EMIT) && cell_w[0].vld && (cell_w[0].cnt == best_r);

  assign ctl.rotate = (state_r == ST_SCAN) || (state_r == ST_EMIT);
  assign ctl.clear  = (state_r == ST_EMIT) && step_end;

  // ---- cell chain --------------------------------------------------------
  assign tok_w[0] = tok_r;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    mvl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1]),
      .data_in  (cell_w[(i + 1) % MAX_ITEMS]),
      .data_out (cell_w[i])
    );
  end

  // ---- control -----------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    set_ovf_nxt   = set_ovf_r;
    best_nxt      = best_r;
    ties_nxt      = ties_r;
    sent_nxt      = sent_r;
    tok_nxt.vld   = 1'b0;
    tok_nxt.val   = mvl_pkg::sat_value(in_value);
    out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            tok_nxt.vld = 1'b1;
            fill_nxt    = fill_r + IW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            set_ovf_nxt = ovf_r || !room;
            fill_nxt    = '0;
            ovf_nxt     = 1'b0;
            best_nxt    = '0;
            ties_nxt    = '0;
            sent_nxt    = '0;
            step_nxt    = '0;
            state_nxt   = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        step_nxt = step_r + SW'(1);
        if (step_end) begin
          step_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        step_nxt = step_r + SW'(1);
        if (cell_w[0].vld) begin
          if (cell_w[0].cnt > best_r) begin
            best_nxt = cell_w[0].cnt;
            ties_nxt = mvl_pkg::CNT_W'(1);
          end else if (cell_w[0].cnt == best_r) begin
            ties_nxt = ties_r + mvl_pkg::CNT_W'(1);
          end
        end
        if (step_end) begin
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        step_nxt = step_r + SW'(1);
        if (hit) begin
          out_valid_nxt = 1'b1;
          sent_nxt      = sent_r + mvl_pkg::CNT_W'(1);
        end
        if (step_end) begin
          step_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      tok_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      tok_r       <= tok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    set_ovf_r <= set_ovf_nxt;
    best_r    <= best_nxt;
    ties_r    <= ties_nxt;
    sent_r    <= sent_nxt;
    out_val_r <= cell_w[0].val;
    out_cnt_r <= cell_w[0].cnt;
    out_ovf_r <= set_ovf_r;
    out_eol_r <= ((sent_r + mvl_pkg::CNT_W'(1)) == ties_r);
  end

  assign out_valid       = out_valid_r;
  assign out_mode_value  = out_val_r;
  assign out_frequency   = out_cnt_r;
  assign out_overflow    = out_ovf_r;
  assign out_end_of_list = out_eol_r;

  // ---- assertions --------------------------------------------------------
  a_out_only_after_emit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_EMIT))
    else $error("result outside emit pass");

  a_final_goes_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> busy)
    else $error("final item did not start the list pass");

  a_freq_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r != '0))
    else $error("listed value with zero count");

  a_sent_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (sent_r <= ties_r))
    else $error("more values emitted than ties found");

endmodule
